>>> hdl/ctds_pkg.sv
// Shared types and constants for the CSR top-k degree selector.
// Item structs for the input and result channels, candidate control bits.
// No dependencies.
`default_nettype none

package ctds_pkg;

  // Fixed width of the payload fields on the ports
  localparam int FIELD_W = 40;
  // Width of the k register and its value after reset
  localparam int TOPK_W = 5;
  localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd16;

  // One row-pointer value of the CSR array
  typedef struct packed {
    logic [FIELD_W-1:0] row_pointer;
    logic               last_pointer;
  } in_item_t;

  // One reported node, or the single empty-list item
  typedef struct packed {
    logic [FIELD_W-1:0] node_index;
    logic [FIELD_W-1:0] node_degree;
    logic [FIELD_W-1:0] active_nodes;
    logic               entry_valid;
    logic               last_result;
  } out_item_t;

  // Control bits that travel with a node candidate
  typedef struct packed {
    logic positive;  // node has a positive degree, insert it
    logic last;      // final value of the array, report the list
  } cand_ctl_t;

endpackage

`default_nettype wire

>>> hdl/csr_topk_degree_select_core.sv
// CSR top-k degree selector, top level: k register, front end, cell chain, result buffer.
// A final row-pointer value passes the input register, candidate register and result
//   buffer before its first result; a new value is accepted every cycle unless stalled.
// A list of up to MAX_K nodes leaves one item per cycle while out_ready_i is high; a
//   second final value waits at the cell chain until the buffer is on its last item.
// Reset clears all stream state and the buffer, and sets k to 16.
`default_nettype none

module csr_topk_degree_select_core #(
  parameter int MAX_K       = 16,
  parameter int OFFSET_BITS = 40
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire ctds_pkg::in_item_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ctds_pkg::out_item_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ctds_pkg::TOPK_W-1:0]       cfg_data_i
);

  localparam int KW = $clog2(MAX_K + 1);

  logic [ctds_pkg::TOPK_W-1:0] topk_q;
  logic [KW-1:0]               k_eff;

  logic                   cand_valid;
  logic                   cand_ready;
  logic [OFFSET_BITS-1:0] cand_idx;
  logic [OFFSET_BITS-1:0] cand_deg;
  logic [OFFSET_BITS-1:0] cand_act;
  ctds_pkg::cand_ctl_t    cand_ctl;

  logic                   snap_valid;
  logic                   snap_ready;
  logic [OFFSET_BITS-1:0] snap_idx [MAX_K];
  logic [OFFSET_BITS-1:0] snap_deg [MAX_K];
  logic [KW-1:0]          snap_cnt;
  logic [OFFSET_BITS-1:0] snap_act;

  // k register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topk_q <= ctds_pkg::TOPK_RESET;
    end else if (cfg_valid_i) begin
      topk_q <= cfg_data_i;
    end
  end

  // Zero acts as one, values above MAX_K act as MAX_K
  always_comb begin
    if (topk_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(topk_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(topk_q);
    end
  end

  ctds_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cand_valid_o (cand_valid),
    .cand_ready_i (cand_ready),
    .cand_idx_o   (cand_idx),
    .cand_deg_o   (cand_deg),
    .cand_act_o   (cand_act),
    .cand_ctl_o   (cand_ctl)
  );

  ctds_chain #(
    .MAX_K       (MAX_K),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_eff_i      (k_eff),
    .cand_valid_i (cand_valid),
    .cand_ready_o (cand_ready),
    .cand_idx_i   (cand_idx),
    .cand_deg_i   (cand_deg),
    .cand_act_i   (cand_act),
    .cand_ctl_i   (cand_ctl),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_idx_o   (snap_idx),
    .snap_deg_o   (snap_deg),
    .snap_cnt_o   (snap_cnt),
    .snap_act_o   (snap_act)
  );

  ctds_emit #(
    .MAX_K       (MAX_K),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_idx_i   (snap_idx),
    .snap_deg_i   (snap_deg),
    .snap_cnt_i   (snap_cnt),
    .snap_act_i   (snap_act),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/ctds_front.sv
// Front end: input register, degree computation and stream counters.
// Produces one node candidate per accepted row-pointer value.
// Depends on ctds_pkg.
`default_nettype none

module ctds_front #(
  parameter int OFFSET_BITS = 40
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire ctds_pkg::in_item_t       in_data_i,
  output logic                          cand_valid_o,
  input  wire logic                     cand_ready_i,
  output logic [OFFSET_BITS-1:0]        cand_idx_o,
  output logic [OFFSET_BITS-1:0]        cand_deg_o,
  output logic [OFFSET_BITS-1:0]        cand_act_o,
  output ctds_pkg::cand_ctl_t           cand_ctl_o
);

  // Input register
  logic                   in_v_q;
  logic [OFFSET_BITS-1:0] cur_q;
  logic                   last_q;

  // Stream state
  logic [OFFSET_BITS-1:0] prev_q;
  logic                   have_q;
  logic [OFFSET_BITS-1:0] node_cnt_q;
  logic [OFFSET_BITS-1:0] act_cnt_q;

  // Candidate register
  logic                   cand_v_q;
  logic [OFFSET_BITS-1:0] cand_idx_q;
  logic [OFFSET_BITS-1:0] cand_deg_q;
  logic [OFFSET_BITS-1:0] cand_act_q;
  ctds_pkg::cand_ctl_t    cand_ctl_q;

  logic                   cand_free;
  logic                   move;
  logic                   positive;
  logic [OFFSET_BITS-1:0] degree;
  logic [OFFSET_BITS-1:0] act_d;
  logic [OFFSET_BITS-1:0] node_cnt_d;

  // Stage handshakes
  assign cand_free  = !cand_v_q || cand_ready_i;
  assign in_ready_o = !in_v_q || cand_free;
  assign move       = in_v_q && cand_free;

  // Degree of the previous node and updated counters
  always_comb begin
    positive   = have_q && (cur_q > prev_q);
    degree     = cur_q - prev_q;
    act_d      = positive ? act_cnt_q + OFFSET_BITS'(1) : act_cnt_q;
    node_cnt_d = have_q ? node_cnt_q + OFFSET_BITS'(1) : node_cnt_q;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_q  <= OFFSET_BITS'(in_data_i.row_pointer);
      last_q <= in_data_i.last_pointer;
    end
  end

  // Stream state; the final value returns it to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      have_q     <= 1'b0;
      node_cnt_q <= '0;
      act_cnt_q  <= '0;
    end else if (move) begin
      if (last_q) begin
        prev_q     <= '0;
        have_q     <= 1'b0;
        node_cnt_q <= '0;
        act_cnt_q  <= '0;
      end else begin
        prev_q     <= cur_q;
        have_q     <= 1'b1;
        node_cnt_q <= node_cnt_d;
        act_cnt_q  <= act_d;
      end
    end
  end

  // Candidate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_v_q <= 1'b0;
    end else if (cand_free) begin
      cand_v_q <= move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      cand_idx_q          <= node_cnt_q;
      cand_deg_q          <= degree;
      cand_act_q          <= act_d;
      cand_ctl_q.positive <= positive;
      cand_ctl_q.last     <= last_q;
    end
  end

  assign cand_valid_o = cand_v_q;
  assign cand_idx_o   = cand_idx_q;
  assign cand_deg_o   = cand_deg_q;
  assign cand_act_o   = cand_act_q;
  assign cand_ctl_o   = cand_ctl_q;

endmodule

`default_nettype wire

>>> hdl/ctds_chain.sv
// Sorted cell chain holding the best nodes seen so far, best first.
// Inserts one candidate per cycle; a final one waits until the emitter takes its snapshot.
// Depends on ctds_pkg.
`default_nettype none

module ctds_chain #(
  parameter int MAX_K       = 16,
  parameter int OFFSET_BITS = 40,
  localparam int KW         = $clog2(MAX_K + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [KW-1:0]          k_eff_i,
  input  wire logic                   cand_valid_i,
  output logic                        cand_ready_o,
  input  wire logic [OFFSET_BITS-1:0] cand_idx_i,
  input  wire logic [OFFSET_BITS-1:0] cand_deg_i,
  input  wire logic [OFFSET_BITS-1:0] cand_act_i,
  input  wire ctds_pkg::cand_ctl_t    cand_ctl_i,
  output logic                        snap_valid_o,
  input  wire logic                   snap_ready_i,
  output logic [OFFSET_BITS-1:0]      snap_idx_o [MAX_K],
  output logic [OFFSET_BITS-1:0]      snap_deg_o [MAX_K],
  output logic [KW-1:0]               snap_cnt_o,
  output logic [OFFSET_BITS-1:0]      snap_act_o
);

  logic [OFFSET_BITS-1:0] idx_q [MAX_K];
  logic [OFFSET_BITS-1:0] deg_q [MAX_K];
  logic [KW-1:0]          cnt_q;

  logic [OFFSET_BITS-1:0] idx_d [MAX_K];
  logic [OFFSET_BITS-1:0] deg_d [MAX_K];
  logic [MAX_K-1:0]       keep;
  logic [KW-1:0]          cnt_eff;
  logic [KW-1:0]          cnt_ins;
  logic                   consume;

  // A final value waits until the emitter can take the list
  assign cand_ready_o = !cand_ctl_i.last || snap_ready_i;
  assign consume      = cand_valid_i && cand_ready_o;

  // Count cut to the current k; count after an insertion
  always_comb begin
    cnt_eff = (cnt_q > k_eff_i) ? k_eff_i : cnt_q;
    cnt_ins = (cnt_eff < k_eff_i) ? cnt_eff + KW'(1) : k_eff_i;
  end

  // Each cell keeps its entry if it beats the candidate, else takes the candidate or shifts down
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      keep[i] = (KW'(i) < cnt_eff) &&
                ((deg_q[i] > cand_deg_i) ||
                 ((deg_q[i] == cand_deg_i) && (idx_q[i] < cand_idx_i)));
    end
    // Head cell takes the candidate unless it beats it
    if (keep[0]) begin
      idx_d[0] = idx_q[0];
      deg_d[0] = deg_q[0];
    end else begin
      idx_d[0] = cand_idx_i;
      deg_d[0] = cand_deg_i;
    end
    for (int i = 1; i < MAX_K; i++) begin
      if (keep[i]) begin
        idx_d[i] = idx_q[i];
        deg_d[i] = deg_q[i];
      end else if (keep[i-1]) begin
        idx_d[i] = cand_idx_i;
        deg_d[i] = cand_deg_i;
      end else begin
        idx_d[i] = idx_q[i-1];
        deg_d[i] = deg_q[i-1];
      end
    end
  end

  // Cell payload
  always_ff @(posedge clk_i) begin
    if (consume && cand_ctl_i.positive) begin
      for (int i = 0; i < MAX_K; i++) begin
        idx_q[i] <= idx_d[i];
        deg_q[i] <= deg_d[i];
      end
    end
  end

  // Fill count; cleared after the list is reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (consume) begin
      if (cand_ctl_i.last) begin
        cnt_q <= '0;
      end else if (cand_ctl_i.positive) begin
        cnt_q <= cnt_ins;
      end
    end
  end

  // Snapshot of the list including the final candidate
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      snap_idx_o[i] = cand_ctl_i.positive ? idx_d[i] : idx_q[i];
      snap_deg_o[i] = cand_ctl_i.positive ? deg_d[i] : deg_q[i];
    end
    snap_cnt_o = cand_ctl_i.positive ? cnt_ins : cnt_eff;
  end

  assign snap_act_o   = cand_act_i;
  assign snap_valid_o = consume && cand_ctl_i.last;

endmodule

`default_nettype wire

>>> hdl/ctds_emit.sv
// Result buffer: holds a reported list and shifts it out one item a cycle while out_ready_i is high.
// An empty list gives a single item with entry_valid low.
// Depends on ctds_pkg.
`default_nettype none

module ctds_emit #(
  parameter int MAX_K       = 16,
  parameter int OFFSET_BITS = 40,
  localparam int KW         = $clog2(MAX_K + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   snap_valid_i,
  output logic                        snap_ready_o,
  input  wire logic [OFFSET_BITS-1:0] snap_idx_i [MAX_K],
  input  wire logic [OFFSET_BITS-1:0] snap_deg_i [MAX_K],
  input  wire logic [KW-1:0]          snap_cnt_i,
  input  wire logic [OFFSET_BITS-1:0] snap_act_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output ctds_pkg::out_item_t         out_data_o
);

  localparam int FieldW = ctds_pkg::FIELD_W;

  logic [OFFSET_BITS-1:0] idx_q [MAX_K];
  logic [OFFSET_BITS-1:0] deg_q [MAX_K];
  logic [OFFSET_BITS-1:0] act_q;
  logic [KW-1:0]          left_q;
  logic                   empty_q;
  logic                   pop;

  assign out_valid_o  = (left_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  assign snap_ready_o = (left_q == '0) || ((left_q == KW'(1)) && out_ready_i);

  // Items left to send
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      empty_q <= 1'b0;
    end else if (snap_valid_i) begin
      if (snap_cnt_i == '0) begin
        left_q  <= KW'(1);
        empty_q <= 1'b1;
      end else begin
        left_q  <= snap_cnt_i;
        empty_q <= 1'b0;
      end
    end else if (pop) begin
      left_q <= left_q - KW'(1);
    end
  end

  // List payload: load on a snapshot, shift toward the head on each item
  always_ff @(posedge clk_i) begin
    if (snap_valid_i) begin
      for (int i = 0; i < MAX_K; i++) begin
        idx_q[i] <= snap_idx_i[i];
        deg_q[i] <= snap_deg_i[i];
      end
      act_q <= snap_act_i;
    end else if (pop) begin
      for (int i = 0; i < MAX_K - 1; i++) begin
        idx_q[i] <= idx_q[i+1];
        deg_q[i] <= deg_q[i+1];
      end
    end
  end

  // Result item from the head of the list
  always_comb begin
    out_data_o.node_index   = empty_q ? '0 : FieldW'(idx_q[0]);
    out_data_o.node_degree  = empty_q ? '0 : FieldW'(deg_q[0]);
    out_data_o.active_nodes = FieldW'(act_q);
    out_data_o.entry_valid  = !empty_q;
    out_data_o.last_result  = (left_q == KW'(1));
  end

endmodule

`default_nettype wire
